FILE: hw/rtl/point_pose_rigid_transform_assert.svh
// ----------------------------------------------------------------------------
// Point pose rigid transform - assertion macros
// Shared property forms for the port checker.
// ----------------------------------------------------------------------------
`ifndef POINT_POSE_RIGID_TRANSFORM_ASSERT_SVH
`define POINT_POSE_RIGID_TRANSFORM_ASSERT_SVH

// Same-cycle implication, off while reset is asserted
`define PRT_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off while reset is asserted
`define PRT_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that also checks reset behavior
`define PRT_ASSERT_RST(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/prt_pkg.sv
// ----------------------------------------------------------------------------
// Point pose rigid transform - package
// Widths, register codes and shared types for the transform pipeline.
// ----------------------------------------------------------------------------
package prt_pkg;

    // Point coordinate width (Q.16 fraction)
    localparam int COORD_W    = 32;
    localparam int COORD_FRAC = 16;
    localparam int COLOR_W    = 32;
    localparam int SHIFT_W    = 32;

    // Quaternion components, Q2.14
    localparam int QUAT_W    = 16;
    localparam int QUAT_FRAC = 14;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Matrix entry forming: products at 2^-28, entries rounded to 2^-14
    localparam int PROD_W     = 2 * QUAT_W;
    localparam int MAT_W      = PROD_W + 3;
    localparam int ENT_DROP   = QUAT_FRAC;
    localparam int ENT_W      = MAT_W - ENT_DROP;
    localparam int ONE_Q28    = 1 << (2 * QUAT_FRAC);
    localparam int ENT_HALF   = 1 << (ENT_DROP - 1);

    // Dot product: entry (2^-14) times coordinate (2^-16), back to 2^-16
    localparam int P_W        = ENT_W + COORD_W;
    localparam int SUM_W      = P_W + 2;
    localparam int DOT_DROP   = QUAT_FRAC;
    localparam int DOT_HALF   = 1 << (DOT_DROP - 1);
    localparam int ROT_W      = SUM_W - DOT_DROP;
    localparam int ADD_W      = ((ROT_W > SHIFT_W) ? ROT_W : SHIFT_W) + 1;

    // Stream payload widths, padded to whole bytes
    localparam int FIELD_W    = 3 * COORD_W + COLOR_W;
    localparam int TDATA_W    = ((FIELD_W + 7) / 8) * 8;
    localparam int PAD_W      = TDATA_W - FIELD_W;

    // Register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_QUAT_W     = 3'd0,
        REG_QUAT_X     = 3'd1,
        REG_QUAT_Y     = 3'd2,
        REG_QUAT_Z     = 3'd3,
        REG_SHIFT_X    = 3'd4,
        REG_SHIFT_Y    = 3'd5,
        REG_SHIFT_Z    = 3'd6,
        REG_POSE_VALID = 3'd7
    } t_cfg_reg;

    typedef logic signed [QUAT_W-1:0]  t_qcomp;
    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic signed [ENT_W-1:0]   t_ent;

    typedef struct packed {
        t_qcomp w;
        t_qcomp x;
        t_qcomp y;
        t_qcomp z;
    } t_quat;

    // Row-major rotation matrix, entry [3*row + col]
    typedef t_ent t_mat [9];

    // Round a 2^-28 value to 2^-14, half toward plus infinity
    function automatic t_ent f_round_ent(input logic signed [MAT_W-1:0] m);
        logic signed [MAT_W-1:0] mr;
        mr = m + MAT_W'(ENT_HALF);
        return mr[MAT_W-1:ENT_DROP];
    endfunction

endpackage

FILE: hw/rtl/point_pose_rigid_transform.sv
// ----------------------------------------------------------------------------
// Point pose rigid transform - top level
// Rotates each streamed point by the configured quaternion and translates it.
// ----------------------------------------------------------------------------
// Accepts one point per clock and delivers one transformed point per clock
// while the output is not held off. Each point passes through five register
// stages (input register, alignment stage, nine entry-by-coordinate
// multiplies, rounded sums, translate and saturate) on its way to the output.
// Backpressure on the output stalls only as far back as needed; the input
// stays ready while any stage is free. The rotation matrix is rebuilt from the
// quaternion registers after a write, via registered products and matrix;
// the alignment stage covers this for a point taken right after the write.
// Points taken while pose_valid is clear are consumed and dropped.
module point_pose_rigid_transform (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // Configuration write port
    input  logic                               i_cfg_we,
    input  logic [prt_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [prt_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    // Point input stream
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [prt_pkg::TDATA_W-1:0]        s_axis_tdata,  // pt_x, pt_y, pt_z, color
    input  logic                               s_axis_tlast,  // last_point
    // Transformed point stream
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [prt_pkg::TDATA_W-1:0]        m_axis_tdata,  // out_x, out_y, out_z, out_color
    output logic                               m_axis_tlast   // out_last
);

    localparam int CW = prt_pkg::COORD_W;

    localparam logic signed [prt_pkg::ADD_W-1:0] SAT_MAX =
        {{(prt_pkg::ADD_W - CW + 1){1'b0}}, {(CW - 1){1'b1}}};
    localparam logic signed [prt_pkg::ADD_W-1:0] SAT_MIN =
        {{(prt_pkg::ADD_W - CW + 1){1'b1}}, {(CW - 1){1'b0}}};

    typedef logic signed [prt_pkg::SHIFT_W-1:0] t_shift;
    typedef logic signed [prt_pkg::P_W-1:0]     t_prod;
    typedef logic signed [prt_pkg::SUM_W-1:0]   t_sum;
    typedef logic signed [prt_pkg::ROT_W-1:0]   t_rot;
    typedef logic signed [prt_pkg::ADD_W-1:0]   t_add;

    // Configuration registers
    prt_pkg::t_quat r_quat;
    t_shift         r_shift [3];
    logic           r_pose_valid;

    prt_pkg::t_mat  w_mat;

    // Pipeline valids and stage enables
    logic r_v1, r_v2, r_v3, r_v4, r_v5;
    logic w_en1, w_en2, w_en3, w_en4, w_en5;

    // Stage payloads
    prt_pkg::t_coord r_pt1 [3];
    prt_pkg::t_coord r_pt2 [3];
    t_prod           r_prod [3][3];
    t_prod           n_prod [3][3];
    t_rot            r_rot [3];
    t_rot            n_rot [3];
    prt_pkg::t_coord r_out [3];
    prt_pkg::t_coord n_out [3];
    logic [prt_pkg::COLOR_W-1:0] r_col [1:5];
    logic                        r_last [1:5];

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quat.w     <= prt_pkg::QUAT_W'(1 << prt_pkg::QUAT_FRAC);
            r_quat.x     <= '0;
            r_quat.y     <= '0;
            r_quat.z     <= '0;
            r_shift[0]   <= '0;
            r_shift[1]   <= '0;
            r_shift[2]   <= '0;
            r_pose_valid <= 1'b0;
        end else if (i_cfg_we) begin
            case (prt_pkg::t_cfg_reg'(i_cfg_idx))
                prt_pkg::REG_QUAT_W:     r_quat.w <= i_cfg_data[prt_pkg::QUAT_W-1:0];
                prt_pkg::REG_QUAT_X:     r_quat.x <= i_cfg_data[prt_pkg::QUAT_W-1:0];
                prt_pkg::REG_QUAT_Y:     r_quat.y <= i_cfg_data[prt_pkg::QUAT_W-1:0];
                prt_pkg::REG_QUAT_Z:     r_quat.z <= i_cfg_data[prt_pkg::QUAT_W-1:0];
                prt_pkg::REG_SHIFT_X:    r_shift[0] <= i_cfg_data[prt_pkg::SHIFT_W-1:0];
                prt_pkg::REG_SHIFT_Y:    r_shift[1] <= i_cfg_data[prt_pkg::SHIFT_W-1:0];
                prt_pkg::REG_SHIFT_Z:    r_shift[2] <= i_cfg_data[prt_pkg::SHIFT_W-1:0];
                prt_pkg::REG_POSE_VALID: r_pose_valid <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    prt_rot_matrix u_rot_matrix (
        .i_clk  (i_clk),
        .i_quat (r_quat),
        .o_mat  (w_mat)
    );

    // A stage advances when it is empty or its successor advances
    assign w_en5 = !r_v5 || m_axis_tready;
    assign w_en4 = !r_v4 || w_en5;
    assign w_en3 = !r_v3 || w_en4;
    assign w_en2 = !r_v2 || w_en3;
    assign w_en1 = !r_v1 || w_en2;
    assign s_axis_tready = w_en1;

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            if (w_en1) r_v1 <= s_axis_tvalid && r_pose_valid;
            if (w_en2) r_v2 <= r_v1;
            if (w_en3) r_v3 <= r_v2;
            if (w_en4) r_v4 <= r_v3;
            if (w_en5) r_v5 <= r_v4;
        end
    end

    // Multiplies, rounded sums, translate and saturate
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                n_prod[i][j] = prt_pkg::P_W'(w_mat[3*i + j]) * prt_pkg::P_W'(r_pt2[j]);
            end
        end
    end

    always_comb begin
        t_sum s;
        for (int i = 0; i < 3; i++) begin
            s = prt_pkg::SUM_W'(r_prod[i][0]) + prt_pkg::SUM_W'(r_prod[i][1])
              + prt_pkg::SUM_W'(r_prod[i][2]) + prt_pkg::SUM_W'(prt_pkg::DOT_HALF);
            n_rot[i] = s[prt_pkg::SUM_W-1:prt_pkg::DOT_DROP];
        end
    end

    always_comb begin
        t_add a;
        for (int i = 0; i < 3; i++) begin
            a = prt_pkg::ADD_W'(r_rot[i]) + prt_pkg::ADD_W'(r_shift[i]);
            if (a > SAT_MAX) begin
                n_out[i] = SAT_MAX[CW-1:0];
            end else if (a < SAT_MIN) begin
                n_out[i] = SAT_MIN[CW-1:0];
            end else begin
                n_out[i] = a[CW-1:0];
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (w_en1) begin
            for (int j = 0; j < 3; j++) begin
                r_pt1[j] <= s_axis_tdata[j*CW +: CW];
            end
            r_col[1]  <= s_axis_tdata[3*CW +: prt_pkg::COLOR_W];
            r_last[1] <= s_axis_tlast;
        end
        if (w_en2) begin
            r_pt2     <= r_pt1;
            r_col[2]  <= r_col[1];
            r_last[2] <= r_last[1];
        end
        if (w_en3) begin
            r_prod    <= n_prod;
            r_col[3]  <= r_col[2];
            r_last[3] <= r_last[2];
        end
        if (w_en4) begin
            r_rot     <= n_rot;
            r_col[4]  <= r_col[3];
            r_last[4] <= r_last[3];
        end
        if (w_en5) begin
            r_out     <= n_out;
            r_col[5]  <= r_col[4];
            r_last[5] <= r_last[4];
        end
    end

    // Output stream
    assign m_axis_tvalid = r_v5;
    assign m_axis_tlast  = r_last[5];
    generate
        if (prt_pkg::PAD_W > 0) begin : g_pad
            assign m_axis_tdata = {{prt_pkg::PAD_W{1'b0}}, r_col[5],
                                   r_out[2], r_out[1], r_out[0]};
        end else begin : g_nopad
            assign m_axis_tdata = {r_col[5], r_out[2], r_out[1], r_out[0]};
        end
    endgenerate

endmodule

FILE: hw/rtl/prt_rot_matrix.sv
// ----------------------------------------------------------------------------
// Point pose rigid transform - rotation matrix builder
// Turns the configured quaternion into a 3x3 Q.14 matrix in two stages.
// ----------------------------------------------------------------------------
module prt_rot_matrix (
    input  logic           i_clk,
    input  prt_pkg::t_quat i_quat,
    output prt_pkg::t_mat  o_mat
);

    typedef logic signed [prt_pkg::PROD_W-1:0] t_prod;
    typedef logic signed [prt_pkg::MAT_W-1:0]  t_wide;

    t_prod r_xx, r_yy, r_zz, r_xy, r_xz, r_yz, r_wx, r_wy, r_wz;
    prt_pkg::t_mat r_mat;
    prt_pkg::t_mat n_mat;

    // 1 - 2(a + b)
    function automatic t_wide f_diag(input t_prod a, input t_prod b);
        t_wide s;
        s = prt_pkg::MAT_W'(a) + prt_pkg::MAT_W'(b);
        return prt_pkg::MAT_W'(prt_pkg::ONE_Q28) - (s <<< 1);
    endfunction

    // 2(a + b) or 2(a - b)
    function automatic t_wide f_off(input t_prod a, input t_prod b, input logic sub);
        t_wide s;
        s = sub ? (prt_pkg::MAT_W'(a) - prt_pkg::MAT_W'(b))
                : (prt_pkg::MAT_W'(a) + prt_pkg::MAT_W'(b));
        return s <<< 1;
    endfunction

    // Stage A: pairwise component products
    always_ff @(posedge i_clk) begin
        r_xx <= i_quat.x * i_quat.x;
        r_yy <= i_quat.y * i_quat.y;
        r_zz <= i_quat.z * i_quat.z;
        r_xy <= i_quat.x * i_quat.y;
        r_xz <= i_quat.x * i_quat.z;
        r_yz <= i_quat.y * i_quat.z;
        r_wx <= i_quat.w * i_quat.x;
        r_wy <= i_quat.w * i_quat.y;
        r_wz <= i_quat.w * i_quat.z;
    end

    // Stage B: matrix entries, rounded to Q.14
    always_comb begin
        n_mat[0] = prt_pkg::f_round_ent(f_diag(r_yy, r_zz));
        n_mat[1] = prt_pkg::f_round_ent(f_off(r_xy, r_wz, 1'b1));
        n_mat[2] = prt_pkg::f_round_ent(f_off(r_xz, r_wy, 1'b0));
        n_mat[3] = prt_pkg::f_round_ent(f_off(r_xy, r_wz, 1'b0));
        n_mat[4] = prt_pkg::f_round_ent(f_diag(r_xx, r_zz));
        n_mat[5] = prt_pkg::f_round_ent(f_off(r_yz, r_wx, 1'b1));
        n_mat[6] = prt_pkg::f_round_ent(f_off(r_xz, r_wy, 1'b1));
        n_mat[7] = prt_pkg::f_round_ent(f_off(r_yz, r_wx, 1'b0));
        n_mat[8] = prt_pkg::f_round_ent(f_diag(r_xx, r_yy));
    end

    always_ff @(posedge i_clk) begin
        r_mat <= n_mat;
    end

    assign o_mat = r_mat;

endmodule

FILE: hw/rtl/prt_checker.sv
// ----------------------------------------------------------------------------
// Point pose rigid transform - port checker
// Watches the top-level stream ports; bound to every instance of the block.
// ----------------------------------------------------------------------------
`include "point_pose_rigid_transform_assert.svh"

module prt_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         s_axis_tvalid,
    input logic                         s_axis_tready,
    input logic                         m_axis_tvalid,
    input logic                         m_axis_tready,
    input logic [prt_pkg::TDATA_W-1:0]  m_axis_tdata,
    input logic                         m_axis_tlast
);

    // Reset empties the pipeline
    `PRT_ASSERT_RST(a_rst_empty, !i_rst_n, !m_axis_tvalid, "output valid after reset")

    // A free or draining output frees every stage, so the input must be ready
    `PRT_ASSERT_IMP(a_in_ready, !m_axis_tvalid || m_axis_tready, s_axis_tready, "input stalled without backpressure")

    // A stalled result holds
    `PRT_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "stalled result changed")

endmodule

bind point_pose_rigid_transform prt_checker u_prt_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

FILE: tb/point_pose_rigid_transform_checker.sv
// ----------------------------------------------------------------------------
// Point pose rigid transform - stream checker
// Follows the register writes and both point streams. Every point request
// taken while a pose is loaded is run through a local model of the rotation
// and translation. Each transformed point that comes out is compared, field
// by field, with the oldest point still owed.
// ----------------------------------------------------------------------------
module point_pose_rigid_transform_checker
    import prt_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    // Register writes, as seen on the block's port
    input  logic               i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // Point input stream
    input  logic               s_axis_tvalid,
    input  logic               s_axis_tready,
    input  logic [TDATA_W-1:0] s_axis_tdata,  // pt_x, pt_y, pt_z, color
    input  logic               s_axis_tlast,  // last_point
    // Transformed point stream
    input  logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    input  logic [TDATA_W-1:0] m_axis_tdata,  // out_x, out_y, out_z, out_color
    input  logic               m_axis_tlast,  // out_last
    // High once the stimulus has drained; points still owed then are failures
    input  logic               i_check_end,
    output int                 o_pending,
    output int                 o_fail_count,
    output int                 o_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        t_coord      x;
        t_coord      y;
        t_coord      z;
        logic [31:0] color;
        logic        last;
    } point_result_t;

    localparam t_coord COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam t_coord COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

    // Local copy of the pose registers
    t_qcomp quat_w, quat_x, quat_y, quat_z;
    t_coord shift_x, shift_y, shift_z;
    logic   pose_valid;

    point_result_t posed_points [$];
    int fail_count;
    int checked;
    logic end_reported;

    // 2^-28 -> 2^-14, half rounds up
    function automatic longint round_entry(input longint m);
        return (m + ENT_HALF) >>> ENT_DROP;
    endfunction

    // One matrix row times the point: 2^-30 -> 2^-16, half rounds up
    function automatic longint rotate_row(input longint e0, e1, e2,
                                          input longint c0, c1, c2);
        return (e0 * c0 + e1 * c1 + e2 * c2 + DOT_HALF) >>> DOT_DROP;
    endfunction

    function automatic t_coord clamp_coord(input longint v);
        if (v > longint'(COORD_MAX))
            return COORD_MAX;
        if (v < longint'(COORD_MIN))
            return COORD_MIN;
        return t_coord'(v[COORD_W-1:0]);
    endfunction

    // Rotate by the loaded quaternion, then translate
    function automatic point_result_t apply_pose(input t_coord px, py, pz,
                                                 input logic [31:0] color,
                                                 input logic last);
        longint w, x, y, z, one;
        longint m [9];
        point_result_t r;
        w = longint'(quat_w);
        x = longint'(quat_x);
        y = longint'(quat_y);
        z = longint'(quat_z);
        one = longint'(ONE_Q28);
        // Unnormalized matrix, row major
        m[0] = round_entry(one - 2 * (y * y + z * z));
        m[1] = round_entry(2 * (x * y - w * z));
        m[2] = round_entry(2 * (x * z + w * y));
        m[3] = round_entry(2 * (x * y + w * z));
        m[4] = round_entry(one - 2 * (x * x + z * z));
        m[5] = round_entry(2 * (y * z - w * x));
        m[6] = round_entry(2 * (x * z - w * y));
        m[7] = round_entry(2 * (y * z + w * x));
        m[8] = round_entry(one - 2 * (x * x + y * y));
        r.x = clamp_coord(rotate_row(m[0], m[1], m[2], px, py, pz) + longint'(shift_x));
        r.y = clamp_coord(rotate_row(m[3], m[4], m[5], px, py, pz) + longint'(shift_y));
        r.z = clamp_coord(rotate_row(m[6], m[7], m[8], px, py, pz) + longint'(shift_z));
        r.color = color;
        r.last = last;
        return r;
    endfunction

    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin : track
        point_result_t want;
        if (!i_rst_n) begin
            quat_w = t_qcomp'(1 << QUAT_FRAC);
            quat_x = '0;
            quat_y = '0;
            quat_z = '0;
            shift_x = '0;
            shift_y = '0;
            shift_z = '0;
            pose_valid = 1'b0;
            posed_points.delete();
            fail_count = 0;
            checked = 0;
            end_reported = 1'b0;
        end else begin
            // Register writes
            if (i_cfg_we) begin
                case (t_cfg_reg'(i_cfg_idx))
                    REG_QUAT_W:     quat_w = t_qcomp'(i_cfg_data[QUAT_W-1:0]);
                    REG_QUAT_X:     quat_x = t_qcomp'(i_cfg_data[QUAT_W-1:0]);
                    REG_QUAT_Y:     quat_y = t_qcomp'(i_cfg_data[QUAT_W-1:0]);
                    REG_QUAT_Z:     quat_z = t_qcomp'(i_cfg_data[QUAT_W-1:0]);
                    REG_SHIFT_X:    shift_x = t_coord'(i_cfg_data[SHIFT_W-1:0]);
                    REG_SHIFT_Y:    shift_y = t_coord'(i_cfg_data[SHIFT_W-1:0]);
                    REG_SHIFT_Z:    shift_z = t_coord'(i_cfg_data[SHIFT_W-1:0]);
                    REG_POSE_VALID: pose_valid = i_cfg_data[0];
                    default: ;
                endcase
            end

            // Result side first, so a point taken this edge cannot match itself
            if (m_axis_tvalid && m_axis_tready) begin
                if (posed_points.size() == 0) begin
                    $error("transformed point with none owed: tdata %h, tlast %b",
                           m_axis_tdata, m_axis_tlast);
                    fail_count++;
                end else begin
                    want = posed_points.pop_front();
                    check_field("out_x", want.x, t_coord'(m_axis_tdata[COORD_W-1:0]));
                    check_field("out_y", want.y,
                                t_coord'(m_axis_tdata[2*COORD_W-1:COORD_W]));
                    check_field("out_z", want.z,
                                t_coord'(m_axis_tdata[3*COORD_W-1:2*COORD_W]));
                    check_field("out_color", longint'(want.color),
                                longint'(m_axis_tdata[3*COORD_W+COLOR_W-1:3*COORD_W]));
                    check_field("out_last", longint'(want.last), longint'(m_axis_tlast));
                    checked++;
                end
            end

            // Point requests; dropped while no pose is loaded
            if (s_axis_tvalid && s_axis_tready && pose_valid)
                posed_points.push_back(apply_pose(
                    t_coord'(s_axis_tdata[COORD_W-1:0]),
                    t_coord'(s_axis_tdata[2*COORD_W-1:COORD_W]),
                    t_coord'(s_axis_tdata[3*COORD_W-1:2*COORD_W]),
                    s_axis_tdata[3*COORD_W+COLOR_W-1:3*COORD_W],
                    s_axis_tlast));

            if (i_check_end && !end_reported) begin
                end_reported = 1'b1;
                if (posed_points.size() != 0) begin
                    $error("%0d transformed points never came out", posed_points.size());
                    fail_count += posed_points.size();
                end
            end
        end
        o_pending <= posed_points.size();
        o_fail_count <= fail_count;
        o_checked <= checked;
    end

endmodule

FILE: tb/point_pose_rigid_transform_test.sv
// ----------------------------------------------------------------------------
// Point pose rigid transform - testbench top
// Loads a series of poses (identity, axis turns, unnormalized and extreme
// quaternions, extreme shifts, pose not loaded) and streams points through
// each, directed corners first and random clouds after, with bursty input
// and a stalling output. The checker predicts and compares; this module
// makes the stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module point_pose_rigid_transform_test;
    timeunit 1ns;
    timeprecision 1ps;
    import prt_pkg::*;

    localparam int     POINT_TARGET = 1700;  // points sent with a pose loaded
    localparam int     DRAIN_CYCLES = 12;    // pipeline is five deep
    localparam int     IDLE_LIMIT   = 4000;
    localparam t_coord COORD_MAX    = {1'b0, {(COORD_W-1){1'b1}}};
    localparam t_coord COORD_MIN    = {1'b1, {(COORD_W-1){1'b0}}};
    localparam t_qcomp Q_ONE        = t_qcomp'(1 << QUAT_FRAC);
    localparam t_qcomp Q_HALF_TURN  = t_qcomp'(11585);  // cos(45 deg) in Q2.14

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [TDATA_W-1:0]    s_axis_tdata;  // pt_x, pt_y, pt_z, color
    logic                  s_axis_tlast;  // last_point
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [TDATA_W-1:0]    m_axis_tdata;  // out_x, out_y, out_z, out_color
    logic                  m_axis_tlast;  // out_last
    logic                  check_end;
    int                    points_owed;
    int                    fail_count;
    int                    points_checked;

    int   burst_left;
    int   posed_sent;
    int   dropped_sent;
    int   pose_count;
    logic pose_loaded;
    int   rx_run;
    int   rx_mode;
    int   idle_cycles;

    point_pose_rigid_transform dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    point_pose_rigid_transform_checker checker_inst (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_check_end   (check_end),
        .o_pending     (points_owed),
        .o_fail_count  (fail_count),
        .o_checked     (points_checked)
    );

    // 20 ns clock
    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // Output side: runs of steady ready, hard stalls and per-cycle coin flips
    always @(posedge i_clk) begin
        if (rx_run == 0) begin
            rx_mode = $urandom_range(0, 2);
            rx_run = (rx_mode == 0) ? $urandom_range(20, 300) : $urandom_range(1, 12);
        end else begin
            rx_run = rx_run - 1;
        end
        case (rx_mode)
            0:       m_axis_tready <= 1'b1;
            1:       m_axis_tready <= 1'b0;
            default: m_axis_tready <= 1'($urandom_range(0, 1));
        endcase
    end

    // Watchdog: too long without any request taken on either stream
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT) begin
            $error("no point request taken for %0d cycles", idle_cycles);
            $display("RESULT: ERROR");
            $finish;
        end else
            idle_cycles <= idle_cycles + 1;
    end

    // One register write per edge; the caller lowers the enable afterwards
    task automatic cfg_write(input t_cfg_reg idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
    endtask

    task automatic load_pose(input t_qcomp qw, qx, qy, qz,
                             input t_coord sx, sy, sz, input logic valid);
        cfg_write(REG_QUAT_W, {{(CFG_DATA_W-QUAT_W){qw[QUAT_W-1]}}, qw});
        cfg_write(REG_QUAT_X, {{(CFG_DATA_W-QUAT_W){qx[QUAT_W-1]}}, qx});
        cfg_write(REG_QUAT_Y, {{(CFG_DATA_W-QUAT_W){qy[QUAT_W-1]}}, qy});
        cfg_write(REG_QUAT_Z, {{(CFG_DATA_W-QUAT_W){qz[QUAT_W-1]}}, qz});
        cfg_write(REG_SHIFT_X, CFG_DATA_W'(sx));
        cfg_write(REG_SHIFT_Y, CFG_DATA_W'(sy));
        cfg_write(REG_SHIFT_Z, CFG_DATA_W'(sz));
        cfg_write(REG_POSE_VALID, CFG_DATA_W'(valid));
        i_cfg_we <= 1'b0;
        pose_loaded = valid;
        pose_count++;
    endtask

    // Send one point request; bursts end in a random gap, which may be zero
    task automatic push_point(input t_coord x, y, z, input logic [31:0] color,
                              input logic last);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= TDATA_W'({color, z, y, x});
        s_axis_tlast <= last;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        if (pose_loaded)
            posed_sent++;
        else
            dropped_sent++;
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 60);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    // Stop sending and hold off until every owed point is out and the
    // pipeline has emptied of dropped points too
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (points_owed != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic t_coord random_coord();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return t_coord'($urandom);
            5, 6, 7:       return t_coord'(int'($urandom_range(0, 1 << 23)) - (1 << 22));
            8: begin
                case ($urandom_range(0, 4))
                    0:       return COORD_MAX;
                    1:       return COORD_MIN;
                    2:       return '0;
                    3:       return '1;
                    default: return t_coord'(1);
                endcase
            end
            // Near zero or near the -2^24 and +2^24 boundaries
            default: return t_coord'(int'($urandom_range(0, 1 << 10)) - (1 << 9)
                                     + (int'($urandom_range(0, 2)) - 1) * (1 << 24));
        endcase
    endfunction

    function automatic t_qcomp extreme_qcomp();
        case ($urandom_range(0, 5))
            0:       return Q_ONE;
            1:       return -Q_ONE;
            2:       return '0;
            3:       return {1'b1, {(QUAT_W-1){1'b0}}};
            4:       return {1'b0, {(QUAT_W-1){1'b1}}};
            default: return Q_HALF_TURN;
        endcase
    endfunction

    function automatic t_coord random_shift();
        case ($urandom_range(0, 5))
            0, 1, 2: return t_coord'(int'($urandom_range(0, 1 << 23)) - (1 << 22));
            3:       return t_coord'($urandom);
            4:       return ($urandom_range(0, 1) == 0) ? COORD_MAX : COORD_MIN;
            default: return '0;
        endcase
    endfunction

    // Unit quaternion from a random direction in four dimensions, or raw
    // or extreme components
    task automatic random_pose();
        real    a [4];
        real    norm;
        t_qcomp q [4];
        int     mode;
        mode = $urandom_range(0, 4);
        norm = 0.0;
        for (int i = 0; i < 4; i++) begin
            a[i] = real'(int'($urandom_range(0, 65534)) - 32767);
            norm = norm + a[i] * a[i];
        end
        norm = $sqrt(norm);
        for (int i = 0; i < 4; i++) begin
            if (mode <= 2)
                q[i] = (norm > 1.0) ? t_qcomp'($rtoi(a[i] / norm * 16384.0)) : '0;
            else if (mode == 3)
                q[i] = t_qcomp'($urandom);
            else
                q[i] = extreme_qcomp();
        end
        load_pose(q[0], q[1], q[2], q[3], random_shift(), random_shift(), random_shift(),
                  $urandom_range(0, 6) != 0);
    endtask

    initial begin
        int n;
        i_rst_n <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_idx <= REG_QUAT_W;
        i_cfg_data <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata <= '0;
        s_axis_tlast <= 1'b0;
        m_axis_tready <= 1'b0;
        check_end <= 1'b0;
        rx_run = 0;
        rx_mode = 0;
        idle_cycles = 0;
        burst_left = $urandom_range(1, 60);
        posed_sent = 0;
        dropped_sent = 0;
        pose_count = 0;
        pose_loaded = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Out of reset no pose is loaded: points are taken and dropped
        push_point(COORD_MAX, COORD_MIN, '0, 32'hDEAD_BEEF, 1'b0);
        push_point('1, t_coord'(1), COORD_MAX, '1, 1'b1);
        push_point('0, '0, '0, '0, 1'b0);
        settle();

        // Identity: coordinate and pass-through extremes
        load_pose(Q_ONE, '0, '0, '0, '0, '0, '0, 1'b1);
        push_point(COORD_MAX, COORD_MIN, '0, '0, 1'b0);
        push_point(COORD_MIN, COORD_MAX, '1, '1, 1'b1);
        push_point('0, '0, '0, 32'hA5A5_5A5A, 1'b0);
        push_point('1, t_coord'(1), t_coord'(32'h0001_0000), 32'h5A5A_A5A5, 1'b1);
        push_point(t_coord'(32'h00FF_FFFF), t_coord'(32'hFF00_0000), t_coord'(32'h1234_5678),
                   32'h0000_0001, 1'b0);
        settle();

        // Quarter turn about z, x shifted to the top of the range
        load_pose(Q_HALF_TURN, '0, '0, Q_HALF_TURN, COORD_MAX, '0, t_coord'(-(1 << 16)), 1'b1);
        push_point(t_coord'(1 << 20), t_coord'(-(1 << 20)), t_coord'(3 << 16), '1, 1'b0);
        push_point(COORD_MAX, COORD_MAX, COORD_MAX, '0, 1'b1);
        push_point(COORD_MIN, '0, '1, 32'h8000_0000, 1'b0);
        settle();

        // Half turn about x, all shifts at the bottom of the range
        load_pose('0, Q_ONE, '0, '0, COORD_MIN, COORD_MIN, COORD_MIN, 1'b1);
        push_point(COORD_MIN, COORD_MIN, COORD_MIN, '0, 1'b1);
        push_point(COORD_MAX, COORD_MAX, COORD_MAX, '1, 1'b0);
        settle();

        // Quaternions that are not unit length scale and skew the point
        load_pose(Q_ONE, Q_ONE, Q_ONE, Q_ONE, '0, '0, '0, 1'b1);
        push_point(t_coord'(1 << 16), t_coord'(2 << 16), t_coord'(-(3 << 16)), '1, 1'b0);
        push_point(COORD_MAX, '0, COORD_MIN, '0, 1'b1);
        settle();
        load_pose({1'b1, {(QUAT_W-1){1'b0}}}, {1'b0, {(QUAT_W-1){1'b1}}},
                  {1'b1, {(QUAT_W-1){1'b0}}}, Q_ONE, t_coord'(1 << 16), '1, '0, 1'b1);
        push_point(t_coord'(5 << 16), t_coord'(-7), t_coord'(32'h0100_0000), 32'h0F0F_F0F0, 1'b0);
        push_point(COORD_MIN, COORD_MAX, '1, 32'hF0F0_0F0F, 1'b1);
        settle();

        // Pose written but not marked valid: still dropped
        load_pose(Q_HALF_TURN, Q_HALF_TURN, '0, '0, t_coord'(5), t_coord'(5), t_coord'(5), 1'b0);
        push_point(t_coord'(1 << 16), t_coord'(1 << 16), t_coord'(1 << 16), '1, 1'b1);
        push_point(COORD_MAX, COORD_MIN, '0, '0, 1'b0);
        settle();

        // Random clouds under random poses
        while (posed_sent < POINT_TARGET) begin
            random_pose();
            n = pose_loaded ? $urandom_range(40, 200) : $urandom_range(5, 20);
            repeat (n)
                push_point(random_coord(), random_coord(), random_coord(), $urandom,
                           $urandom_range(0, 15) == 0);
            settle();
        end

        check_end <= 1'b1;
        repeat (2) @(posedge i_clk);
        $display("Sent %0d points under %0d pose settings, %0d of them with no pose loaded.",
                 posed_sent + dropped_sent, pose_count, dropped_sent);
        $display("Compared %0d transformed points with both streams stalling at random.",
                 points_checked);
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
